@@ src/mrrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrrt_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_BEGIN   = 3'd0;
    localparam logic [2:0] FUNC_CANCEL  = 3'd1;
    localparam logic [2:0] FUNC_TIMEOUT = 3'd2;
    localparam logic [2:0] FUNC_REPLY   = 3'd3;
    localparam logic [2:0] FUNC_SELECT  = 3'd4;
    localparam logic [2:0] FUNC_EXIT    = 3'd5;

    // Mode codes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ALL   = 2'd1;
    localparam logic [1:0] MODE_FALSE = 2'd2;

    // Reply result codes.
    localparam logic [2:0] RES_NONE      = 3'd0;
    localparam logic [2:0] RES_INVALID   = 3'd1;
    localparam logic [2:0] RES_IGNORED   = 3'd2;
    localparam logic [2:0] RES_EXITED    = 3'd3;
    localparam logic [2:0] RES_CONFIRMED = 3'd4;
    localparam logic [2:0] RES_FAILED    = 3'd5;
    localparam logic [2:0] RES_UPDATED   = 3'd6;
    localparam logic [2:0] RES_UNKNOWN   = 3'd7;

    // Reply status bytes.
    localparam logic [7:0] ST_ALL_DATA = 8'h01;
    localparam logic [7:0] ST_INFO     = 8'h02;
    localparam logic [7:0] ST_FALSE    = 8'h03;
    localparam logic [7:0] ST_BUSY     = 8'h05;
    localparam logic [7:0] ST_REJECT   = 8'h06;
    localparam logic [7:0] ST_NONE     = 8'hFF;

    // Shortest reply frame that carries a status byte.
    localparam logic [7:0] MIN_REPLY_LENGTH = 8'd6;

    // Configuration register indexes and reset values.
    localparam logic CFG_REQUEST_TIMEOUT = 1'b0;
    localparam logic CFG_LATE_GUARD      = 1'b1;
    localparam logic [31:0] REQUEST_TIMEOUT_RESET = 32'd1000;
    localparam logic [31:0] LATE_GUARD_RESET      = 32'd3000;

    // One input transaction.
    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  req_mode;
        logic [31:0] now_ms;
        logic [7:0]  status_code;
        logic [7:0]  reply_length;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic        accepted;
        logic [2:0]  reply_result;
        logic [1:0]  current_mode;
        logic        request_pending;
    } result_t;

    // Configuration values handed to the tracking core.
    typedef struct packed {
        logic [31:0] request_timeout_ms;
        logic [31:0] late_guard_ms;
    } cfg_t;

    // Status byte that a reply carries when it confirms the given mode.
    function automatic logic [7:0] expected_status(input logic [1:0] mode);
        logic [7:0] st;
        begin
            if (mode == MODE_ALL) st = ST_ALL_DATA;
            else if (mode == MODE_FALSE) st = ST_FALSE;
            else st = ST_NONE;
            return st;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/mrrt_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrt_cfg_regs
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic          wr_index,
    input  wire logic [31:0]   wr_data,
    output mrrt_pkg::cfg_t     cfg
);

    logic [31:0] request_timeout_reg;
    logic [31:0] late_guard_reg;

    // Register file written one register per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_timeout_reg <= mrrt_pkg::REQUEST_TIMEOUT_RESET;
            late_guard_reg      <= mrrt_pkg::LATE_GUARD_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mrrt_pkg::CFG_REQUEST_TIMEOUT: request_timeout_reg <= wr_data;
                mrrt_pkg::CFG_LATE_GUARD:      late_guard_reg      <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg.request_timeout_ms = request_timeout_reg;
    assign cfg.late_guard_ms      = late_guard_reg;

endmodule

`default_nettype wire

@@ src/mrrt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrt_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire mrrt_pkg::item_t  item,
    input  wire mrrt_pkg::cfg_t   cfg,
    output mrrt_pkg::result_t     result
);

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic        pending_reg;
    logic        pending_next;
    logic [1:0]  wanted_reg;
    logic [1:0]  wanted_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [1:0]  late_wanted_reg;
    logic [1:0]  late_wanted_next;
    logic [31:0] guard_start_reg;
    logic [31:0] guard_start_next;

    logic        accepted;
    logic [2:0]  reply_result;
    logic [31:0] req_elapsed;
    logic [31:0] guard_elapsed;
    logic        guard_armed;
    logic        guard_expired;
    logic        guard_match;
    logic        pending_match;
    logic        known_mode_status;

    // Elapsed times wrap modulo 2^32.
    assign req_elapsed   = item.now_ms - start_reg;
    assign guard_elapsed = item.now_ms - guard_start_reg;
    assign guard_armed   = (guard_start_reg != 32'd0);
    assign guard_expired = (guard_elapsed >= cfg.late_guard_ms);
    assign guard_match   = (item.status_code == mrrt_pkg::expected_status(late_wanted_reg));
    assign pending_match = pending_reg &&
                           (item.status_code == mrrt_pkg::expected_status(wanted_reg));
    assign known_mode_status = (item.status_code == mrrt_pkg::ST_ALL_DATA) ||
                               (item.status_code == mrrt_pkg::ST_FALSE) ||
                               (item.status_code == mrrt_pkg::ST_NONE);

    // Next state and result of the transaction at the head of the pipeline.
    always_comb
    begin
        mode_next        = mode_reg;
        pending_next     = pending_reg;
        wanted_next      = wanted_reg;
        start_next       = start_reg;
        late_wanted_next = late_wanted_reg;
        guard_start_next = guard_start_reg;
        accepted         = 1'b0;
        reply_result     = mrrt_pkg::RES_NONE;

        unique case (item.func)
            mrrt_pkg::FUNC_BEGIN:
            begin
                if ((item.req_mode <= mrrt_pkg::MODE_FALSE) && !pending_reg)
                begin
                    pending_next     = 1'b1;
                    wanted_next      = item.req_mode;
                    start_next       = item.now_ms;
                    guard_start_next = 32'd0;
                    late_wanted_next = mrrt_pkg::MODE_NONE;
                    accepted         = 1'b1;
                end
            end
            mrrt_pkg::FUNC_CANCEL:
            begin
                pending_next = 1'b0;
                wanted_next  = mrrt_pkg::MODE_NONE;
                start_next   = 32'd0;
            end
            mrrt_pkg::FUNC_TIMEOUT:
            begin
                if (pending_reg && (req_elapsed >= cfg.request_timeout_ms))
                begin
                    pending_next     = 1'b0;
                    wanted_next      = mrrt_pkg::MODE_NONE;
                    start_next       = 32'd0;
                    late_wanted_next = wanted_reg;
                    guard_start_next = item.now_ms;
                    accepted         = 1'b1;
                end
            end
            mrrt_pkg::FUNC_REPLY:
            begin
                priority if (item.reply_length < mrrt_pkg::MIN_REPLY_LENGTH)
                begin
                    reply_result = mrrt_pkg::RES_INVALID;
                end
                else if (guard_armed && !guard_expired && guard_match)
                begin
                    // A late reply to the timed-out request is swallowed.
                    guard_start_next = 32'd0;
                    late_wanted_next = mrrt_pkg::MODE_NONE;
                    reply_result     = mrrt_pkg::RES_IGNORED;
                end
                else
                begin
                    // An expired window is disarmed before normal handling.
                    if (guard_armed && guard_expired)
                    begin
                        guard_start_next = 32'd0;
                        late_wanted_next = mrrt_pkg::MODE_NONE;
                    end
                    priority if (pending_match)
                    begin
                        pending_next = 1'b0;
                        wanted_next  = mrrt_pkg::MODE_NONE;
                        start_next   = 32'd0;
                        mode_next    = wanted_reg;
                        reply_result = (wanted_reg == mrrt_pkg::MODE_NONE) ?
                                       mrrt_pkg::RES_EXITED : mrrt_pkg::RES_CONFIRMED;
                    end
                    else if (pending_reg && known_mode_status)
                    begin
                        reply_result = mrrt_pkg::RES_IGNORED;
                    end
                    else if (item.status_code == mrrt_pkg::ST_REJECT)
                    begin
                        if (pending_reg)
                        begin
                            pending_next = 1'b0;
                            wanted_next  = mrrt_pkg::MODE_NONE;
                            start_next   = 32'd0;
                            reply_result = mrrt_pkg::RES_FAILED;
                        end
                        else
                        begin
                            reply_result = mrrt_pkg::RES_UPDATED;
                        end
                    end
                    else if (item.status_code == mrrt_pkg::ST_NONE)
                    begin
                        mode_next    = mrrt_pkg::MODE_NONE;
                        reply_result = mrrt_pkg::RES_EXITED;
                    end
                    else if ((item.status_code == mrrt_pkg::ST_ALL_DATA) ||
                             (item.status_code == mrrt_pkg::ST_INFO) ||
                             (item.status_code == mrrt_pkg::ST_FALSE) ||
                             (item.status_code == mrrt_pkg::ST_BUSY))
                    begin
                        reply_result = mrrt_pkg::RES_UPDATED;
                    end
                    else
                    begin
                        reply_result = mrrt_pkg::RES_UNKNOWN;
                    end
                end
            end
            mrrt_pkg::FUNC_SELECT:
            begin
                if ((item.req_mode == mrrt_pkg::MODE_ALL) ||
                    (item.req_mode == mrrt_pkg::MODE_FALSE))
                begin
                    mode_next = item.req_mode;
                end
            end
            mrrt_pkg::FUNC_EXIT:
            begin
                mode_next = mrrt_pkg::MODE_NONE;
            end
            default: ;
        endcase
    end

    // Tracker state advances once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= mrrt_pkg::MODE_NONE;
            pending_reg     <= 1'b0;
            wanted_reg      <= mrrt_pkg::MODE_NONE;
            start_reg       <= 32'd0;
            late_wanted_reg <= mrrt_pkg::MODE_NONE;
            guard_start_reg <= 32'd0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            pending_reg     <= pending_next;
            wanted_reg      <= wanted_next;
            start_reg       <= start_next;
            late_wanted_reg <= late_wanted_next;
            guard_start_reg <= guard_start_next;
        end
    end

    assign result.accepted        = accepted;
    assign result.reply_result    = reply_result;
    assign result.current_mode    = mode_next;
    assign result.request_pending = pending_next;

endmodule

`default_nettype wire

@@ src/mode_request_reply_tracker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Mode request/reply tracker.
// Input channel in_valid / in_stall / in_data carries one operation per
// transaction: begin, cancel, timeout check, reply, select or exit.
// Output channel out_valid / out_stall / out_data returns exactly one result
// per input transaction, in order.
// Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data writes
// the request timeout (index 0) or late guard window (index 1); cfg_ready is
// always high. Write only while no transaction is in flight.
// An accepted transaction waits in the input register and its result is then
// loaded into the result register once that register is free. Throughput is
// one transaction per cycle while the receiver does not stall, set by the
// single pass of decision logic between those two registers.
// When the receiver stalls, the result register holds its value; an empty input
// register takes one more transaction, and only then is in_stall raised.
// Reset clears the tracker state, loads the register reset values and
// empties both pipeline registers.
module mode_request_reply_tracker_unit
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mrrt_pkg::item_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output mrrt_pkg::result_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);

    logic              in_valid_reg;
    mrrt_pkg::item_t   in_data_reg;
    logic              out_valid_reg;
    mrrt_pkg::result_t out_data_reg;
    logic              advance;
    mrrt_pkg::cfg_t    cfg;
    mrrt_pkg::result_t result;

    assign cfg_ready = 1'b1;

    // The held transaction moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    mrrt_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mrrt_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ src/mrrt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrt_checker
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire mrrt_pkg::item_t   in_data,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire mrrt_pkg::result_t out_data
);

    // The input side is only held back by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could drain");

    // A result never reports both an accepted operation and a reply outcome.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.accepted &&
                        (out_data.reply_result != mrrt_pkg::RES_NONE)))
        else $error("result carries both accepted and a reply outcome");

    // A confirmed or failed reply always ends the pending request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_data.reply_result == mrrt_pkg::RES_CONFIRMED) ||
                       (out_data.reply_result == mrrt_pkg::RES_FAILED)))
        |-> !out_data.request_pending)
        else $error("request still pending after a confirming or failing reply");

    // A stalled result transaction is held unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or was dropped");

    // A stalled input transaction is held unchanged by the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
        else $error("stalled input changed or was withdrawn");

endmodule

bind mode_request_reply_tracker_unit mrrt_checker u_mrrt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
